// ===== rtl/core/ascii_integer_parser_assert.svh =====
// ----------------------------------------------------------------------------
// ASCII integer parser assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and held off
// during reset.
// ----------------------------------------------------------------------------
`ifndef ASCII_INTEGER_PARSER_ASSERT_SVH
`define ASCII_INTEGER_PARSER_ASSERT_SVH

// Same-cycle implication
`define AIP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define AIP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/aip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII integer parser package
// Codes, character constants and small character-class functions.
// ----------------------------------------------------------------------------
package aip_pkg;

   // Result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_PARTIAL = 2'd1;
   localparam logic [1:0] STATUS_ERROR   = 2'd2;

   // base_mode register codes
   localparam logic [1:0] BASE_AUTO = 2'd0;
   localparam logic [1:0] BASE_HEX  = 2'd1;
   localparam logic [1:0] BASE_DEC  = 2'd2;
   localparam logic [1:0] BASE_OCT  = 2'd3;

   // target_type register codes
   localparam logic [1:0] TARGET_U32 = 2'd0;
   localparam logic [1:0] TARGET_S32 = 2'd1;
   localparam logic [1:0] TARGET_U64 = 2'd2;
   localparam logic [1:0] TARGET_S64 = 2'd3;

   // Internal radix codes
   localparam logic [1:0] RADIX_DEC = 2'd0;
   localparam logic [1:0] RADIX_HEX = 2'd1;
   localparam logic [1:0] RADIX_OCT = 2'd2;

   // Digit tracking codes
   localparam logic [1:0] SEEN_NONE   = 2'd0;
   localparam logic [1:0] SEEN_PREFIX = 2'd1;
   localparam logic [1:0] SEEN_DIGITS = 2'd2;

   // Register select (word index from the address)
   localparam logic REG_BASE_MODE   = 1'b0;
   localparam logic REG_TARGET_TYPE = 1'b1;

   // Characters
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_SEVEN   = 8'h37;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_UPPER_X = 8'h58;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;

   // Digit value for a non-alphanumeric character
   localparam logic [5:0] DIGIT_NONE = 6'd63;

   // Range limits
   localparam logic [63:0] INT32_MIN_MAG   = 64'h0000_0000_8000_0000;
   localparam logic [63:0] INT32_MIN_VALUE = 64'hFFFF_FFFF_8000_0000;
   localparam logic [63:0] INT64_MIN_MAG   = 64'h8000_0000_0000_0000;

   // Space, tab, newline, vertical tab, form feed, carriage return
   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   // 0-9 then letters of either case as 10-35
   function automatic logic [5:0] digit_value(input logic [7:0] c);
      logic [7:0] v;
      v = {2'b00, DIGIT_NONE};
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         v = c - CHAR_ZERO;
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         v = c - CHAR_UPPER_A + 8'd10;
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         v = c - CHAR_LOWER_A + 8'd10;
      end
      return v[5:0];
   endfunction

   function automatic logic [4:0] radix_value(input logic [1:0] code);
      logic [4:0] r;
      unique case (code)
         RADIX_HEX: r = 5'd16;
         RADIX_OCT: r = 5'd8;
         default:   r = 5'd10;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/ascii_integer_parser.sv =====
`timescale 1ns / 1ps
// Result path: a terminator waits in the input register until the result register
//   is free; its result is then loaded into the result register, driving rsp_valid.
// Throughput: one item per cycle; a terminator stalls only while an earlier result
//   waits. The digit shift-add and range check each take a single pass of logic.
// Reset: synchronous, active high; clears the valid flags, the configuration
//   registers and the parse state.
// ----------------------------------------------------------------------------
// ASCII integer parser
// Streams number text a byte per item, detects or forces the base, accumulates
// digits with exact 64-bit overflow detection and range-checks on the
// terminator item, giving one result with value and status.
// ----------------------------------------------------------------------------
`include "ascii_integer_parser_assert.svh"

module ascii_integer_parser (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_number_value,
   output logic [1:0]  rsp_parse_status,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import aip_pkg::*;

   typedef enum logic [2:0] {
      PH_LEAD, PH_BODY, PH_ZERO, PH_DIGITS, PH_TRAIL, PH_JUNK, PH_ERROR
   } phase_type;

   // Configuration
   logic [1:0]  base_mode_ff, base_mode_in;
   logic [1:0]  target_type_ff, target_type_in;
   logic        csr_write;

   // Input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   logic        in_end_ff, in_end_in;
   logic        advance;

   // Parse state
   phase_type   phase_ff, phase_in;
   logic        negative_ff, negative_in;
   logic [1:0]  radix_ff, radix_in;
   logic [63:0] acc_ff, acc_in;
   logic [1:0]  seen_ff, seen_in;

   // Digit step
   logic        byte_space;
   logic [5:0]  byte_digit;
   logic [1:0]  forced_radix;
   logic        take_digit;
   logic [63:0] step_acc;
   logic [67:0] step_sum;

   // Result
   logic [63:0] res_mag;
   logic        res_negative;
   logic [1:0]  res_status;
   logic [63:0] res_value;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_value_ff, rsp_value_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic        rsp_load;

   // Configuration port: writes on the access phase, reads by word index
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      base_mode_in   = base_mode_ff;
      target_type_in = target_type_ff;
      if (csr_write) begin
         if (csr_paddr[2] == REG_BASE_MODE) begin
            base_mode_in = csr_pwdata[1:0];
         end else begin
            target_type_in = csr_pwdata[1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_TARGET_TYPE) ? {30'd0, target_type_ff}
                                                        : {30'd0, base_mode_ff};

   // Handshake: a terminator only moves on when the result register is free
   assign advance   = in_valid_ff & (~in_end_ff | ~rsp_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign rsp_load  = advance & in_end_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_end_in   = in_end_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_byte_in  = req_text_byte;
         in_end_in   = req_end_of_text;
      end
   end

   // Character classes of the registered byte
   assign byte_space = is_space(in_byte_ff);
   assign byte_digit = digit_value(in_byte_ff);

   always_comb begin
      unique case (base_mode_ff)
         BASE_HEX: forced_radix = RADIX_HEX;
         BASE_OCT: forced_radix = RADIX_OCT;
         default:  forced_radix = RADIX_DEC;
      endcase
   end

   // Parse state update for one text byte
   always_comb begin
      phase_in    = phase_ff;
      negative_in = negative_ff;
      radix_in    = radix_ff;
      acc_in      = acc_ff;
      seen_in     = seen_ff;
      take_digit  = 1'b0;
      step_acc    = acc_ff;
      step_sum    = '0;

      if (advance && !in_end_ff) begin
         unique case (phase_ff)
            PH_LEAD, PH_BODY: begin
               if (phase_ff == PH_LEAD && byte_space) begin
                  phase_in = PH_LEAD;
               end else if (phase_ff == PH_LEAD && in_byte_ff == CHAR_MINUS) begin
                  negative_in = 1'b1;
                  phase_in    = PH_BODY;
               end else if (phase_ff == PH_LEAD && in_byte_ff == CHAR_PLUS) begin
                  negative_in = 1'b0;
                  phase_in    = PH_BODY;
               end else if (base_mode_ff != BASE_AUTO) begin
                  radix_in   = forced_radix;
                  phase_in   = PH_DIGITS;
                  take_digit = 1'b1;
               end else if (in_byte_ff == CHAR_ZERO) begin
                  phase_in = PH_ZERO;
               end else begin
                  radix_in   = RADIX_DEC;
                  phase_in   = PH_DIGITS;
                  take_digit = 1'b1;
               end
            end
            PH_ZERO: begin
               // byte after a leading zero picks hex, octal or decimal
               step_acc = '0;
               acc_in   = '0;
               phase_in = PH_DIGITS;
               if (in_byte_ff == CHAR_LOWER_X || in_byte_ff == CHAR_UPPER_X) begin
                  radix_in = RADIX_HEX;
                  seen_in  = SEEN_PREFIX;
               end else begin
                  radix_in = (in_byte_ff >= CHAR_ZERO && in_byte_ff <= CHAR_SEVEN)
                             ? RADIX_OCT : RADIX_DEC;
                  seen_in    = SEEN_DIGITS;
                  take_digit = 1'b1;
               end
            end
            PH_DIGITS: take_digit = 1'b1;
            PH_TRAIL: begin
               if (!byte_space) begin
                  phase_in = PH_JUNK;
               end
            end
            default: phase_in = phase_ff;
         endcase

         // Shift-add by the radix, 68 bits wide so overflow is exact
         unique case (radix_in)
            RADIX_HEX: step_sum = {step_acc, 4'b0000} + 68'(byte_digit);
            RADIX_OCT: step_sum = {1'b0, step_acc, 3'b000} + 68'(byte_digit);
            default:   step_sum = {3'b000, step_acc, 1'b0} + {1'b0, step_acc, 3'b000}
                                  + 68'(byte_digit);
         endcase

         if (take_digit) begin
            if (byte_digit >= {1'b0, radix_value(radix_in)}) begin
               if (seen_in == SEEN_NONE) begin
                  phase_in = PH_ERROR;
               end else begin
                  phase_in = byte_space ? PH_TRAIL : PH_JUNK;
               end
            end else begin
               seen_in = SEEN_DIGITS;
               if (|step_sum[67:64]) begin
                  phase_in = PH_ERROR;
               end else begin
                  acc_in = step_sum[63:0];
               end
            end
         end
      end else if (advance) begin
         // terminator: back to the start of a new number
         phase_in    = PH_LEAD;
         negative_in = 1'b0;
         radix_in    = RADIX_DEC;
         acc_in      = '0;
         seen_in     = SEEN_NONE;
      end
   end

   // Raw status, then the range check of the target type
   always_comb begin
      res_mag      = acc_ff;
      res_negative = negative_ff;
      res_value    = '0;
      unique case (phase_ff)
         PH_LEAD: begin
            res_status   = STATUS_PARTIAL;
            res_negative = 1'b0;
            res_mag      = '0;
         end
         PH_ZERO: begin
            res_status = STATUS_OK;
            res_mag    = '0;
         end
         PH_DIGITS, PH_TRAIL: begin
            if (seen_ff == SEEN_NONE) begin
               res_status = STATUS_ERROR;
            end else begin
               res_status = (seen_ff == SEEN_PREFIX) ? STATUS_PARTIAL : STATUS_OK;
            end
         end
         PH_JUNK: res_status = STATUS_PARTIAL;
         default: res_status = STATUS_ERROR;
      endcase

      if (res_status != STATUS_ERROR) begin
         unique case (target_type_ff)
            TARGET_U32: begin
               if (res_negative || (|res_mag[63:32])) res_status = STATUS_ERROR;
               else res_value = res_mag;
            end
            TARGET_S32: begin
               if (res_negative && res_mag == INT32_MIN_MAG) res_value = INT32_MIN_VALUE;
               else if (|res_mag[63:31]) res_status = STATUS_ERROR;
               else res_value = res_negative ? -res_mag : res_mag;
            end
            TARGET_U64: begin
               if (res_negative) res_status = STATUS_ERROR;
               else res_value = res_mag;
            end
            default: begin
               if (res_negative && res_mag == INT64_MIN_MAG) res_value = res_mag;
               else if (res_mag[63]) res_status = STATUS_ERROR;
               else res_value = res_negative ? -res_mag : res_mag;
            end
         endcase
      end
      if (res_status == STATUS_ERROR) begin
         res_value = '0;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = res_value;
         rsp_status_in = res_status;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_number_value = rsp_value_ff;
   assign rsp_parse_status = rsp_status_ff;

   // Control and parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         base_mode_ff   <= BASE_AUTO;
         target_type_ff <= TARGET_U32;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         phase_ff       <= PH_LEAD;
         negative_ff    <= 1'b0;
         radix_ff       <= RADIX_DEC;
         acc_ff         <= '0;
         seen_ff        <= SEEN_NONE;
      end else begin
         base_mode_ff   <= base_mode_in;
         target_type_ff <= target_type_in;
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         phase_ff       <= phase_in;
         negative_ff    <= negative_in;
         radix_ff       <= radix_in;
         acc_ff         <= acc_in;
         seen_ff        <= seen_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      in_end_ff     <= in_end_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Assertions
   `AIP_ASSERT_SAME(a_error_value_zero, rsp_valid_ff && rsp_status_ff == STATUS_ERROR,
      rsp_value_ff == 64'd0, "error result carries a non-zero value")
   `AIP_ASSERT_NEXT(a_terminator_clears, rsp_load,
      phase_ff == PH_LEAD && acc_ff == 64'd0 && seen_ff == SEEN_NONE && !negative_ff,
      "parse state not cleared after terminator")
   `AIP_ASSERT_SAME(a_prefix_state, seen_ff == SEEN_PREFIX,
      radix_ff == RADIX_HEX && acc_ff == 64'd0, "hex prefix with digits or wrong radix")

endmodule

// ===== bench/tb_ascii_integer_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII integer parser testbench
// Streams number text into the parser a byte per item under every base mode
// and target type, predicts each terminator's value and status with a
// behavioural copy of the parse, and checks every result in order. Both
// channels idle in random bursts; register writes happen only while idle.
// ----------------------------------------------------------------------------
module tb_ascii_integer_parser;
   import aip_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_ITEMS    = 120;
   localparam int PRINT_CAP      = 100;

   // Parse progress of the prediction
   typedef enum logic [2:0] {
      SCAN_LEAD, SCAN_SIGN, SCAN_ZERO, SCAN_DIGITS, SCAN_TRAIL, SCAN_JUNK, SCAN_ERROR
   } scan_phase_type;

   typedef struct packed {
      logic [63:0] value;
      logic [1:0]  status;
   } parsed_number_type;

   // Predicts the parse and holds the results still owed by the block
   class number_parse_checker;
      logic [1:0]        base_mode;
      logic [1:0]        target_type;
      scan_phase_type    phase;
      bit                negative;
      logic [1:0]        radix_code;
      logic [63:0]       accumulator;
      logic [1:0]        digits_seen;
      parsed_number_type expected_numbers[$];
      int                mismatches;

      function new();
         base_mode   = BASE_AUTO;
         target_type = TARGET_U32;
         mismatches  = 0;
         restart_number();
      endfunction

      function void restart_number();
         phase       = SCAN_LEAD;
         negative    = 0;
         radix_code  = RADIX_DEC;
         accumulator = '0;
         digits_seen = SEEN_NONE;
      endfunction

      function void set_register(input logic sel, input logic [1:0] value);
         if (sel == REG_BASE_MODE) begin
            base_mode = value;
         end else begin
            target_type = value;
         end
      endfunction

      function int pending();
         return expected_numbers.size();
      endfunction

      function bit is_blank(input logic [7:0] c);
         case (c)
            CHAR_SPACE, CHAR_TAB, 8'h0A, 8'h0B, 8'h0C, CHAR_CR: return 1;
            default: return 0;
         endcase
      endfunction

      // Letters fold to lower case; anything else scores above every radix
      function int char_digit(input logic [7:0] c);
         logic [7:0] folded;
         folded = c | 8'h20;
         if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
         if (folded >= CHAR_LOWER_A && folded <= CHAR_LOWER_Z)
            return int'(folded - CHAR_LOWER_A) + 10;
         return 99;
      endfunction

      function int radix_number();
         case (radix_code)
            RADIX_HEX: return 16;
            RADIX_OCT: return 8;
            default:   return 10;
         endcase
      endfunction

      // Shift-add one digit; the top bits of the wide sum flag overflow
      function void take_digit(input logic [7:0] c);
         int         d;
         int         r;
         logic [68:0] wide;
         logic [68:0] rw;
         logic [68:0] dw;
         d = char_digit(c);
         r = radix_number();
         if (d >= r) begin
            if (digits_seen == SEEN_NONE) phase = SCAN_ERROR;
            else phase = is_blank(c) ? SCAN_TRAIL : SCAN_JUNK;
            return;
         end
         digits_seen = SEEN_DIGITS;
         rw = r;
         dw = d;
         wide = {5'd0, accumulator} * rw + dw;
         if (wide[68:64] != 0) phase = SCAN_ERROR;
         else accumulator = wide[63:0];
      endfunction

      function void start_body(input logic [7:0] c);
         if (base_mode != BASE_AUTO) begin
            case (base_mode)
               BASE_HEX: radix_code = RADIX_HEX;
               BASE_DEC: radix_code = RADIX_DEC;
               default:  radix_code = RADIX_OCT;
            endcase
            phase = SCAN_DIGITS;
            take_digit(c);
         end else if (c == CHAR_ZERO) begin
            phase = SCAN_ZERO;
         end else begin
            radix_code = RADIX_DEC;
            phase = SCAN_DIGITS;
            take_digit(c);
         end
      endfunction

      // Character after a leading zero picks hex, octal or decimal
      function void after_leading_zero(input logic [7:0] c);
         accumulator = '0;
         phase = SCAN_DIGITS;
         if (c == CHAR_LOWER_X || c == CHAR_UPPER_X) begin
            radix_code  = RADIX_HEX;
            digits_seen = SEEN_PREFIX;
         end else begin
            radix_code  = (c >= CHAR_ZERO && c <= CHAR_SEVEN) ? RADIX_OCT : RADIX_DEC;
            digits_seen = SEEN_DIGITS;
            take_digit(c);
         end
      endfunction

      // Terminator: raw status, then the target range check
      function parsed_number_type finish_number();
         parsed_number_type n;
         logic [63:0]       mag;
         logic [1:0]        st;
         mag = accumulator;
         n.value = '0;
         case (phase)
            SCAN_LEAD: begin
               st = STATUS_PARTIAL;
               negative = 0;
               mag = '0;
            end
            SCAN_ZERO: begin
               st = STATUS_OK;
               mag = '0;
            end
            SCAN_DIGITS, SCAN_TRAIL: begin
               if (digits_seen == SEEN_NONE) st = STATUS_ERROR;
               else if (digits_seen == SEEN_PREFIX) st = STATUS_PARTIAL;
               else st = STATUS_OK;
            end
            SCAN_JUNK: st = STATUS_PARTIAL;
            default:   st = STATUS_ERROR;
         endcase
         if (st != STATUS_ERROR) begin
            case (target_type)
               TARGET_U32: begin
                  if (negative || mag > 64'h0000_0000_FFFF_FFFF) st = STATUS_ERROR;
                  else n.value = mag;
               end
               TARGET_S32: begin
                  if (negative && mag == INT32_MIN_MAG) n.value = INT32_MIN_VALUE;
                  else if (mag > 64'h0000_0000_7FFF_FFFF) st = STATUS_ERROR;
                  else n.value = negative ? 64'd0 - mag : mag;
               end
               TARGET_U64: begin
                  if (negative) st = STATUS_ERROR;
                  else n.value = mag;
               end
               default: begin
                  if (negative && mag == INT64_MIN_MAG) n.value = mag;
                  else if (mag > 64'h7FFF_FFFF_FFFF_FFFF) st = STATUS_ERROR;
                  else n.value = negative ? 64'd0 - mag : mag;
               end
            endcase
         end
         if (st == STATUS_ERROR) n.value = '0;
         n.status = st;
         return n;
      endfunction

      // Accepted input item
      function void note_byte(input logic [7:0] c, input logic eot);
         if (eot) begin
            expected_numbers.push_back(finish_number());
            restart_number();
            return;
         end
         case (phase)
            SCAN_LEAD: begin
               if (!is_blank(c)) begin
                  if (c == CHAR_MINUS) begin
                     negative = 1;
                     phase = SCAN_SIGN;
                  end else if (c == CHAR_PLUS) begin
                     negative = 0;
                     phase = SCAN_SIGN;
                  end else begin
                     start_body(c);
                  end
               end
            end
            SCAN_SIGN:   start_body(c);
            SCAN_ZERO:   after_leading_zero(c);
            SCAN_DIGITS: take_digit(c);
            SCAN_TRAIL:  if (!is_blank(c)) phase = SCAN_JUNK;
            default: ;
         endcase
      endfunction

      task report_mismatch(input string what);
         mismatches++;
         if (mismatches <= PRINT_CAP) $display("%0t MISMATCH: %s", $time, what);
      endtask

      // Accepted result against the oldest expectation
      task check_number(input logic [63:0] value, input logic [1:0] status);
         parsed_number_type want;
         if (expected_numbers.size() == 0) begin
            report_mismatch($sformatf("unexpected result value %h status %0d",
                                      value, status));
            return;
         end
         want = expected_numbers.pop_front();
         if (value !== want.value)
            report_mismatch($sformatf("number_value %h, expected %h", value, want.value));
         if (status !== want.status)
            report_mismatch($sformatf("parse_status %0d, expected %0d",
                                      status, want.status));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_text_byte = 8'd0;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_number_value;
   logic [1:0]  rsp_parse_status;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   number_parse_checker chk = new();

   bit          calm = 0;
   int          phase_items = 0;
   logic [1:0]  gen_base_mode = BASE_AUTO;
   logic [7:0]  text_q[$];

   ascii_integer_parser dut (.*);

   always #2 clock = ~clock;

   // Result channel monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         chk.check_number(rsp_number_value, rsp_parse_status);
   end

   // Receiver: random stall bursts, none once the run turns calm
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
         end else if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            hold = $urandom_range(0, 3);
         end else begin
            rsp_ready <= 1'b1;
            hold = $urandom_range(0, 7);
         end
      end
   end

   // Watchdog on cycles without any handshake
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_psel && csr_penable)) quiet = 0;
         else quiet++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // One input item, after an optional gap
   task automatic push_char(input logic [7:0] c, input logic eot);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_text_byte   <= c;
      req_end_of_text <= eot;
      do @(posedge clock); while (!req_ready);
      chk.note_byte(c, eot);
      phase_items++;
   endtask

   // Queued text then a terminator carrying a random byte
   task automatic send_text_q();
      foreach (text_q[i]) push_char(text_q[i], 1'b0);
      push_char(8'($urandom_range(0, 255)), 1'b1);
      text_q.delete();
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
      send_text_q();
   endtask

   // Drop valid, drain the results, then let the pipeline empty
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (chk.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write a register, then read it back
   task automatic write_register(input logic sel, input logic [1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= {30'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      chk.set_register(sel, value);
      if (sel == REG_BASE_MODE) gen_base_mode = value;
      @(negedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== {30'd0, value})
         chk.report_mismatch($sformatf("register %0d reads %h, expected %0d",
                                       sel, csr_prdata, value));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 5))
         0: return CHAR_SPACE;
         1: return CHAR_TAB;
         2: return 8'h0A;
         3: return 8'h0B;
         4: return 8'h0C;
         default: return CHAR_CR;
      endcase
   endfunction

   // Characters that steer the parse into its corner cases
   function automatic logic [7:0] edgy_char();
      case ($urandom_range(0, 11))
         0: return CHAR_PLUS;
         1: return CHAR_MINUS;
         2: return CHAR_ZERO;
         3: return CHAR_LOWER_X;
         4: return CHAR_UPPER_X;
         5: return CHAR_NINE;
         6: return CHAR_SEVEN;
         7: return 8'h38;
         8: return CHAR_LOWER_A;
         9: return CHAR_UPPER_Z;
         10: return 8'h67;
         default: return CHAR_SPACE;
      endcase
   endfunction

   // Magnitude near a range edge, of random width, or small
   function automatic logic [65:0] pick_magnitude();
      logic [95:0] raw;
      int          w;
      case ($urandom_range(0, 2))
         0: begin
            case ($urandom_range(0, 11))
               0: return 66'd0;
               1: return 66'd1;
               2: return 66'h0_0000_0000_7FFF_FFFF;
               3: return 66'h0_0000_0000_8000_0000;
               4: return 66'h0_0000_0000_8000_0001;
               5: return 66'h0_0000_0000_FFFF_FFFF;
               6: return 66'h0_0000_0001_0000_0000;
               7: return 66'h0_7FFF_FFFF_FFFF_FFFF;
               8: return 66'h0_8000_0000_0000_0000;
               9: return 66'h0_8000_0000_0000_0001;
               10: return 66'h0_FFFF_FFFF_FFFF_FFFF;
               default: return 66'h1_0000_0000_0000_0000;
            endcase
         end
         1: begin
            raw = {$urandom, $urandom, $urandom};
            w = $urandom_range(1, 66);
            return raw[65:0] >> (66 - w);
         end
         default: return 66'($urandom_range(0, 999));
      endcase
   endfunction

   task automatic push_number(input logic [65:0] mag, input int radix);
      logic [7:0]  digits[$];
      logic [65:0] m;
      int          d;
      m = mag;
      if (m == 0) digits.push_front(CHAR_ZERO);
      while (m != 0) begin
         d = int'(m % radix);
         m = m / radix;
         if (d < 10) digits.push_front(CHAR_ZERO + 8'(d));
         else if ($urandom_range(0, 1)) digits.push_front(CHAR_LOWER_A + 8'(d - 10));
         else digits.push_front(CHAR_UPPER_A + 8'(d - 10));
      end
      foreach (digits[i]) text_q.push_back(digits[i]);
   endtask

   // Well-formed number with random content and optional tail
   task automatic build_number_text();
      int radix;
      bit digits_wanted;
      radix = 10;
      digits_wanted = 1;
      repeat ($urandom_range(0, 2)) text_q.push_back(blank_char());
      case ($urandom_range(0, 3))
         0: text_q.push_back(CHAR_MINUS);
         1: text_q.push_back(CHAR_PLUS);
         default: ;
      endcase
      if (gen_base_mode == BASE_AUTO) begin
         case ($urandom_range(0, 3))
            0: begin
               text_q.push_back(CHAR_ZERO);
               text_q.push_back($urandom_range(0, 1) ? CHAR_LOWER_X : CHAR_UPPER_X);
               radix = 16;
               digits_wanted = ($urandom_range(0, 7) != 0);
            end
            1: begin
               text_q.push_back(CHAR_ZERO);
               radix = 8;
            end
            2: radix = 10;
            default: begin
               text_q.push_back(CHAR_ZERO);
               digits_wanted = 0;
            end
         endcase
      end else begin
         case (gen_base_mode)
            BASE_HEX: radix = 16;
            BASE_DEC: radix = 10;
            default:  radix = 8;
         endcase
         // a hex prefix means nothing in a forced base
         if ($urandom_range(0, 7) == 0) begin
            text_q.push_back(CHAR_ZERO);
            text_q.push_back(CHAR_LOWER_X);
         end
      end
      if (digits_wanted) push_number(pick_magnitude(), radix);
      repeat ($urandom_range(0, 2)) text_q.push_back(blank_char());
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // Broken or random text
   task automatic build_noise_text();
      repeat ($urandom_range(0, 6)) begin
         if ($urandom_range(0, 1)) text_q.push_back(8'($urandom_range(0, 255)));
         else text_q.push_back(edgy_char());
      end
   endtask

   initial begin
      int setting;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: prefix, zero, sign and junk corners at reset settings
      send_string("0x");
      send_string("0");
      send_string("-0");
      send_string(" 17z");
      send_string("\t");
      send_string("+");
      send_string("\377");
      send_string("010");
      push_char(8'h00, 1'b0);
      push_char(8'hFF, 1'b1);

      // Every base mode against every target type
      for (setting = 0; setting < 16; setting++) begin
         settle();
         write_register(REG_BASE_MODE, 2'(setting / 4));
         write_register(REG_TARGET_TYPE, 2'(setting % 4));
         calm = (setting >= 13);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            if ($urandom_range(0, 4) == 0) build_noise_text();
            else build_number_text();
            send_text_q();
         end
      end

      settle();
      repeat (6) @(posedge clock);
      if (chk.pending() != 0)
         chk.report_mismatch($sformatf("%0d results never arrived", chk.pending()));
      if (chk.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
